### rtl/core/ukt_pkg.sv
// ---------------------------------------------------------------------------
// ukt_pkg
// shared types and codes for the unique key table engine
// ---------------------------------------------------------------------------
package ukt_pkg;

    localparam int DEFAULT_CAPACITY = 128;

    typedef enum logic [2:0] {
        OP_INSERT = 3'd0,
        OP_DELETE = 3'd1,
        OP_CLEAR  = 3'd2,
        OP_LOOKUP = 3'd3,
        OP_SORT   = 3'd4,
        OP_READ   = 3'd5
    } op_t;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_FULL  = 3'd1,
        ST_DUP   = 3'd2,
        ST_MISS  = 3'd3,
        ST_EMPTY = 3'd4,
        ST_RANGE = 3'd5
    } status_t;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic        shift_down;   // load from upper neighbor at and above base
        logic        sort_even;    // compare-exchange on pairs starting even
        logic        sort_odd;     // compare-exchange on pairs starting odd
        logic        write_tail;   // write new entry at tail position
    } cell_cmd_t;

endpackage

### rtl/core/ukt_cell.sv
// ---------------------------------------------------------------------------
// ukt_cell
// one table slot: holds key and record, moves data with its neighbors
// ---------------------------------------------------------------------------
module ukt_cell
    import ukt_pkg::*;
#(
    parameter int IDX_W = 7,
    parameter logic [IDX_W-1:0] POS = '0
)
(
    input  logic                    clk,
    input  cell_cmd_t               cmd,
    input  logic [IDX_W-1:0]        base,      // shift start or tail position
    input  logic [IDX_W:0]          count,
    input  logic [31:0]             new_key,
    input  logic [31:0]             new_record,
    input  logic [31:0]             up_key,    // neighbor above
    input  logic [31:0]             up_record,
    input  logic [31:0]             dn_key,    // neighbor below
    input  logic [31:0]             dn_record,
    input  logic                    match_in,  // some lower cell matched
    input  logic                    lookup_en,
    output logic [31:0]             key,
    output logic [31:0]             record,
    output logic                    match_out,
    output logic                    first_hit
);

    logic [31:0] key_reg, key_next;
    logic [31:0] record_reg, record_next;
    logic        in_use;
    logic        hit;
    logic        is_lower;    // lower element of its compare pair
    logic        pair_ok;
    logic        even_pos;
    logic        up_less;
    logic        dn_greater;

    assign in_use     = {1'b0, POS} < count;
    assign hit        = lookup_en && in_use && (key_reg == new_key);
    assign first_hit  = hit && !match_in;
    assign match_out  = hit || match_in;
    assign even_pos   = ~POS[0];
    assign is_lower   = cmd.sort_even ? even_pos : ~even_pos;
    assign up_less    = $signed(up_key) < $signed(key_reg);
    assign dn_greater = $signed(dn_key) > $signed(key_reg);

    always_comb
    begin
        key_next    = key_reg;
        record_next = record_reg;
        pair_ok     = 1'b0;
        if (cmd.write_tail && POS == base)
        begin
            key_next    = new_key;
            record_next = new_record;
        end
        else if (cmd.shift_down && POS >= base)
        begin
            key_next    = up_key;
            record_next = up_record;
        end
        else if (cmd.sort_even || cmd.sort_odd)
        begin
            if (is_lower)
            begin
                pair_ok = ({1'b0, POS} + 1'b1) < count;
                if (pair_ok && up_less)
                begin
                    key_next    = up_key;
                    record_next = up_record;
                end
            end
            else
            begin
                pair_ok = (POS != '0) && in_use;
                if (pair_ok && dn_greater)
                begin
                    key_next    = dn_key;
                    record_next = dn_record;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg    <= key_next;
        record_reg <= record_next;
    end

    assign key    = key_reg;
    assign record = record_reg;

endmodule

### rtl/core/unique_key_table_engine.sv
// ---------------------------------------------------------------------------
// unique_key_table_engine
// keyed table of unique signed keys held in a chain of cells
// ---------------------------------------------------------------------------
// states: read, clear, lookup and insert pass through S_SEARCH and S_DONE;
// delete on a hit adds an S_SHIFT step; sort of a non-empty table adds CAPACITY
// odd-even transposition passes in S_SORT; handshake: one item at a time, the
// next item is accepted only after the result is taken
// reset: entry count cleared, output invalid; cell contents undefined
module unique_key_table_engine
    import ukt_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  kind,
    input  logic signed [31:0] entry_key,
    input  logic [31:0] entry_record,
    input  logic [6:0]  read_index,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic signed [31:0] found_key,
    output logic [31:0] found_record,
    output logic [6:0]  found_index,
    output logic [7:0]  entry_count
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = IDX_W + 1;
    localparam int SW_W  = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_SEARCH, S_SHIFT, S_SORT, S_DONE
    } state_t;

    state_t          state_reg;
    logic [CNT_W-1:0] count_reg;
    logic [2:0]      kind_reg;
    logic [31:0]     key_reg;
    logic [31:0]     rec_reg;
    logic [6:0]      ridx_reg;
    logic [IDX_W-1:0] base_reg;
    logic [SW_W-1:0] sweep_reg;
    logic            phase_reg;

    logic [2:0]      status_reg;
    logic [31:0]     fkey_reg;
    logic [31:0]     frec_reg;
    logic [6:0]      fidx_reg;
    logic            out_valid_reg;

    cell_cmd_t       cmd;
    logic [31:0]     cell_key   [CAPACITY];
    logic [31:0]     cell_rec   [CAPACITY];
    logic [CAPACITY:0] match_chain;
    logic [CAPACITY-1:0] first_hit;
    logic            lookup_en;

    // hit position and entry, one-hot or
    logic [IDX_W-1:0] hit_pos;
    logic [31:0]     hit_key;
    logic [31:0]     hit_rec;
    logic            any_hit;

    logic full;
    assign full = count_reg == CNT_W'(CAPACITY);

    assign lookup_en      = (state_reg == S_SEARCH);
    assign match_chain[0] = 1'b0;
    assign any_hit        = match_chain[CAPACITY];

    // a full table takes no tail write
    always_comb
    begin
        cmd            = '0;
        cmd.shift_down = (state_reg == S_SHIFT);
        cmd.sort_even  = (state_reg == S_SORT) && !phase_reg;
        cmd.sort_odd   = (state_reg == S_SORT) && phase_reg;
        cmd.write_tail = (state_reg == S_SEARCH) && (kind_reg == OP_INSERT)
                         && !any_hit && !full;
    end

    always_comb
    begin
        hit_pos = '0;
        hit_key = '0;
        hit_rec = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (first_hit[i])
            begin
                hit_pos = hit_pos | IDX_W'(i);
                hit_key = hit_key | cell_key[i];
                hit_rec = hit_rec | cell_rec[i];
            end
        end
    end

    // cells: tail write uses count as base, shift uses delete position
    logic [IDX_W-1:0] cell_base;
    assign cell_base = cmd.write_tail ? count_reg[IDX_W-1:0] : base_reg;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            ukt_cell #(
                .IDX_W (IDX_W),
                .POS   (IDX_W'(g))
            ) u_cell (
                .clk        (clk),
                .cmd        (cmd),
                .base       (cell_base),
                .count      (count_reg),
                .new_key    (key_reg),
                .new_record (rec_reg),
                .up_key     (cell_key[(g + 1) % CAPACITY]),
                .up_record  (cell_rec[(g + 1) % CAPACITY]),
                .dn_key     (cell_key[(g + CAPACITY - 1) % CAPACITY]),
                .dn_record  (cell_rec[(g + CAPACITY - 1) % CAPACITY]),
                .match_in   (match_chain[g]),
                .lookup_en  (lookup_en),
                .key        (cell_key[g]),
                .record     (cell_rec[g]),
                .match_out  (match_chain[g + 1]),
                .first_hit  (first_hit[g])
            );
        end
    endgenerate

    // read port: index into the cells, registered in S_SEARCH
    logic [IDX_W-1:0] rd_pos;
    logic             rd_in_range;
    assign rd_in_range = {{(CNT_W > 7 ? CNT_W - 7 : 0){1'b0}}, ridx_reg} < count_reg;
    assign rd_pos      = IDX_W'(ridx_reg);

    assign in_ready = (state_reg == S_IDLE) && !out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            phase_reg     <= 1'b0;
            sweep_reg     <= '0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        kind_reg  <= kind;
                        key_reg   <= entry_key;
                        rec_reg   <= entry_record;
                        ridx_reg  <= read_index;
                        state_reg <= S_SEARCH;
                    end
                end
                S_SEARCH:
                begin
                    status_reg <= ST_OK;
                    fkey_reg   <= '0;
                    frec_reg   <= '0;
                    fidx_reg   <= '0;
                    state_reg  <= S_DONE;
                    case (kind_reg)
                        OP_INSERT:
                        begin
                            if (full)
                                status_reg <= ST_FULL;
                            else if (any_hit)
                            begin
                                status_reg <= ST_DUP;
                                fkey_reg   <= hit_key;
                                frec_reg   <= hit_rec;
                                fidx_reg   <= 7'(hit_pos);
                            end
                            else
                            begin
                                fkey_reg  <= key_reg;
                                frec_reg  <= rec_reg;
                                fidx_reg  <= 7'(count_reg);
                                count_reg <= count_reg + 1'b1;
                            end
                        end
                        OP_DELETE, OP_LOOKUP:
                        begin
                            if (count_reg == '0)
                                status_reg <= ST_EMPTY;
                            else if (!any_hit)
                                status_reg <= ST_MISS;
                            else
                            begin
                                fkey_reg <= hit_key;
                                frec_reg <= hit_rec;
                                fidx_reg <= 7'(hit_pos);
                                if (kind_reg == OP_DELETE)
                                begin
                                    base_reg  <= hit_pos;
                                    count_reg <= count_reg - 1'b1;
                                    state_reg <= S_SHIFT;
                                end
                            end
                        end
                        OP_CLEAR:
                        begin
                            if (count_reg == '0)
                                status_reg <= ST_EMPTY;
                            count_reg <= '0;
                        end
                        OP_SORT:
                        begin
                            if (count_reg == '0)
                                status_reg <= ST_EMPTY;
                            else
                            begin
                                sweep_reg <= '0;
                                phase_reg <= 1'b0;
                                state_reg <= S_SORT;
                            end
                        end
                        OP_READ:
                        begin
                            if (!rd_in_range)
                                status_reg <= ST_RANGE;
                            else
                            begin
                                fkey_reg <= cell_key[rd_pos];
                                frec_reg <= cell_rec[rd_pos];
                                fidx_reg <= ridx_reg;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                S_SHIFT:
                begin
                    state_reg <= S_DONE;
                end
                S_SORT:
                begin
                    // CAPACITY alternating passes sort any fill level
                    phase_reg <= ~phase_reg;
                    sweep_reg <= sweep_reg + 1'b1;
                    if (sweep_reg == SW_W'(CAPACITY - 1))
                        state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign found_key    = fkey_reg;
    assign found_record = frec_reg;
    assign found_index  = fidx_reg;
    assign entry_count  = 8'(count_reg);

endmodule

### verif/unique_key_table_checker.sv
// ---------------------------------------------------------------------------
// unique_key_table_checker
// watches both channels of the key table engine, predicts each result from
// its own copy of the table and compares every result field by field
// ---------------------------------------------------------------------------
module unique_key_table_checker
    import ukt_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [2:0]         kind,
    input  logic signed [31:0] entry_key,
    input  logic [31:0]        entry_record,
    input  logic [6:0]         read_index,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [2:0]         status,
    input  logic signed [31:0] found_key,
    input  logic [31:0]        found_record,
    input  logic [6:0]         found_index,
    input  logic [7:0]         entry_count,
    output int                 error_count,
    output int                 pending_count
);

    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] fkey;
        logic [31:0]        frec;
        logic [6:0]         fidx;
        logic [7:0]         count;
    } table_result_t;

    logic signed [31:0] key_copy [CAPACITY];
    logic [31:0]        rec_copy [CAPACITY];
    int                 used;
    table_result_t      expected_results [$];

    assign pending_count = expected_results.size();

    function automatic int find_entry(logic signed [31:0] k);
        for (int i = 0; i < used; i++)
            if (key_copy[i] == k)
                return i;
        return used;
    endfunction

    task automatic apply_operation(logic [2:0] op, logic signed [31:0] k,
                                   logic [31:0] r, logic [6:0] idx);
        table_result_t res;
        int pos;
        logic signed [31:0] tk;
        logic [31:0] tr;
        res = '0;
        res.status = ST_OK;
        pos = -1;
        case (op)
            OP_INSERT:
                if (used >= CAPACITY)
                    res.status = ST_FULL;
                else
                begin
                    pos = find_entry(k);
                    if (pos < used)
                        res.status = ST_DUP;
                    else
                    begin
                        key_copy[pos] = k;
                        rec_copy[pos] = r;
                        used++;
                    end
                end
            OP_DELETE:
                if (used == 0)
                    res.status = ST_EMPTY;
                else
                begin
                    pos = find_entry(k);
                    if (pos >= used)
                    begin
                        res.status = ST_MISS;
                        pos = -1;
                    end
                    else
                    begin
                        res.fkey = key_copy[pos];
                        res.frec = rec_copy[pos];
                        res.fidx = pos[6:0];
                        for (int i = pos; i + 1 < used; i++)
                        begin
                            key_copy[i] = key_copy[i + 1];
                            rec_copy[i] = rec_copy[i + 1];
                        end
                        used--;
                        pos = -1;
                    end
                end
            OP_CLEAR:
                if (used == 0)
                    res.status = ST_EMPTY;
                else
                    used = 0;
            OP_LOOKUP:
                if (used == 0)
                    res.status = ST_EMPTY;
                else
                begin
                    pos = find_entry(k);
                    if (pos >= used)
                    begin
                        res.status = ST_MISS;
                        pos = -1;
                    end
                end
            OP_SORT:
                if (used == 0)
                    res.status = ST_EMPTY;
                else
                    for (int i = 0; i + 1 < used; i++)
                        for (int j = i + 1; j < used; j++)
                            if (key_copy[i] > key_copy[j])
                            begin
                                tk = key_copy[i];
                                tr = rec_copy[i];
                                key_copy[i] = key_copy[j];
                                rec_copy[i] = rec_copy[j];
                                key_copy[j] = tk;
                                rec_copy[j] = tr;
                            end
            OP_READ:
                if (int'(idx) >= used)
                    res.status = ST_RANGE;
                else
                    pos = idx;
            default: ;
        endcase
        if (pos >= 0)
        begin
            res.fkey = key_copy[pos];
            res.frec = rec_copy[pos];
            res.fidx = pos[6:0];
        end
        res.count = used[7:0];
        expected_results.push_back(res);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        table_result_t exp_r;
        if (!rst_n)
        begin
            used = 0;
            error_count = 0;
            expected_results.delete();
        end
        else
        begin
            if (in_valid && in_ready)
                apply_operation(kind, entry_key, entry_record, read_index);
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected result status=%0d", $time, status);
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (status !== exp_r.status || found_key !== exp_r.fkey
                        || found_record !== exp_r.frec || found_index !== exp_r.fidx
                        || entry_count !== exp_r.count)
                    begin
                        error_count++;
                        $display("%0t: mismatch expected st=%0d key=%0d rec=%h idx=%0d cnt=%0d",
                                 $time, exp_r.status, exp_r.fkey, exp_r.frec,
                                 exp_r.fidx, exp_r.count);
                        $display("%0t:          actual   st=%0d key=%0d rec=%h idx=%0d cnt=%0d",
                                 $time, status, found_key, found_record,
                                 found_index, entry_count);
                    end
                end
            end
        end
    end

endmodule

### verif/unique_key_table_engine_tb.sv
// ---------------------------------------------------------------------------
// unique_key_table_engine_tb
// drives table commands in bursts against a stalling receiver; the checker
// beside the block predicts and compares every result
// ---------------------------------------------------------------------------
module unique_key_table_engine_tb;
    import ukt_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [2:0]         kind;
    logic signed [31:0] entry_key;
    logic [31:0]        entry_record;
    logic [6:0]         read_index;
    logic               out_valid;
    logic               out_ready;
    logic [2:0]         status;
    logic signed [31:0] found_key;
    logic [31:0]        found_record;
    logic [6:0]         found_index;
    logic [7:0]         entry_count;
    int                 error_count;
    int                 pending_count;
    int                 idle_cycles;
    bit                 long_hold;

    // small pool of keys so that duplicates, hits and deletes are common
    logic signed [31:0] key_pool [16];

    unique_key_table_engine uut (.*);

    unique_key_table_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // receiver: out_ready drawn at random, plus one long hold-off once long_hold is set
    initial
    begin
        int mode;
        bit hold_done;
        hold_done = 1'b0;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold && !hold_done)
            begin
                out_ready <= 1'b0;
                repeat (400) @(posedge clk);
                hold_done = 1'b1;
            end
            mode = $urandom_range(0, 9);
            if (mode < 3)
                out_ready <= 1'b1;
            else if (mode < 8)
                out_ready <= $urandom_range(0, 1);
            else
                out_ready <= 1'b0;
        end
    end

    // watchdog on cycles with no accepted item on either channel
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT)
        begin
            $display("unique_key_table_engine verification failed");
            $finish;
        end
    end

    // hand one item to the block and wait for acceptance
    task automatic send_item(logic [2:0] op, logic signed [31:0] k,
                             logic [31:0] r, logic [6:0] idx);
        in_valid     <= 1'b1;
        kind         <= op;
        entry_key    <= k;
        entry_record <= r;
        read_index   <= idx;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic pause_sender();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic signed [31:0] pick_key();
        if ($urandom_range(0, 9) < 8)
            return key_pool[$urandom_range(0, 15)];
        return $urandom;
    endfunction

    function automatic logic [2:0] pick_kind(int fill_phase);
        int w;
        w = $urandom_range(0, 99);
        // mostly inserts while filling, mixed traffic otherwise
        if (fill_phase)
            return (w < 85) ? 3'(OP_INSERT) : 3'(OP_READ);
        if (w < 30) return OP_INSERT;
        if (w < 45) return OP_DELETE;
        if (w < 48) return OP_CLEAR;
        if (w < 65) return OP_LOOKUP;
        if (w < 70) return OP_SORT;
        if (w < 97) return OP_READ;
        return 3'($urandom_range(6, 7));
    endfunction

    initial
    begin
        int burst;
        int fill_phase;
        in_valid      = 1'b0;
        kind          = OP_INSERT;
        entry_key     = '0;
        entry_record  = '0;
        read_index    = '0;
        rst_n         = 1'b0;
        long_hold     = 1'b0;
        for (int i = 0; i < 16; i++)
            key_pool[i] = $urandom;
        key_pool[0] = 32'sh8000_0000;
        key_pool[1] = 32'sh7fff_ffff;
        key_pool[2] = 0;
        key_pool[3] = -1;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table cases, then extremes and every operation
        send_item(OP_DELETE, 5, 0, 0);
        send_item(OP_CLEAR, 0, 0, 0);
        send_item(OP_LOOKUP, 5, 0, 0);
        send_item(OP_SORT, 0, 0, 0);
        send_item(OP_READ, 0, 0, 0);
        send_item(3'd6, 0, 0, 0);
        send_item(3'd7, -1, '1, 7'h7f);
        send_item(OP_INSERT, 32'sh7fff_ffff, 32'hffff_ffff, 0);
        send_item(OP_INSERT, 32'sh8000_0000, 32'h0, 7'h7f);
        send_item(OP_INSERT, 0, 32'h5a5a_a5a5, 0);
        send_item(OP_INSERT, -1, 32'ha5a5_5a5a, 0);
        send_item(OP_INSERT, 0, 32'h1234_5678, 0);
        send_item(OP_LOOKUP, -1, 0, 0);
        send_item(OP_LOOKUP, 77, 0, 0);
        send_item(OP_DELETE, 77, 0, 0);
        send_item(OP_SORT, 0, 0, 0);
        send_item(OP_READ, 0, 0, 0);
        send_item(OP_READ, 3, 0, 3);
        send_item(OP_READ, 0, 0, 7'h7f);
        send_item(OP_DELETE, 32'sh8000_0000, 0, 0);
        send_item(OP_READ, 0, 0, 1);
        send_item(OP_CLEAR, 0, 0, 0);
        // fill to capacity with distinct keys, then probe full
        for (int i = 0; i < DEFAULT_CAPACITY; i++)
            send_item(OP_INSERT, 32'($urandom_range(0, 1) ? -i : i * 3 + 1),
                      $urandom, 7'($urandom));
        send_item(OP_INSERT, 32'sh1234, 0, 0);
        send_item(OP_INSERT, 1, 0, 0);
        send_item(OP_SORT, 0, 0, 0);
        send_item(OP_READ, 0, 0, 7'h7f);
        send_item(OP_DELETE, 1, 0, 0);
        send_item(OP_CLEAR, 0, 0, 0);

        // sender waits until every expected result has come
        pause_sender();
        while (pending_count != 0)
            @(posedge clk);

        // random: bursts and gaps; long receiver hold-off partway through
        for (int n = 0; n < 800; )
        begin
            burst = $urandom_range(1, 20);
            fill_phase = ($urandom_range(0, 3) == 0);
            if (n >= 300)
                long_hold = 1'b1;
            for (int b = 0; b < burst; b++)
            begin
                send_item(pick_kind(fill_phase), pick_key(), $urandom,
                          7'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 20)));
                n++;
            end
            if ($urandom_range(0, 2) != 0)
                repeat ($urandom_range(1, 12)) pause_sender();
        end
        in_valid <= 1'b0;

        while (pending_count != 0)
            @(posedge clk);
        repeat (DEFAULT_CAPACITY + 20) @(posedge clk);
        if (error_count == 0)
            $display("unique_key_table_engine verification clean");
        else
            $display("unique_key_table_engine verification failed");
        $finish;
    end

endmodule
